// File: rtl/segment_pair_intersect_near_top_defines.svh
// Assertion macros for the segment pair intersect block.
`ifndef SEGMENT_PAIR_INTERSECT_NEAR_TOP_DEFINES_SVH
`define SEGMENT_PAIR_INTERSECT_NEAR_TOP_DEFINES_SVH

// Generic clocked check, disabled while the active-low reset is asserted.
`define SGI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the block clock and reset.
`define SGI_CHK(lbl, prop, msg) `SGI_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: rtl/sgi_pkg.sv
// Shared constants for the segment pair intersect block.
package sgi_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int LIMIT_BITS     = 16;
    localparam int LIM2_BITS      = 2 * LIMIT_BITS;
endpackage

// File: rtl/segment_pair_intersect_near_top.sv
// Top level of the segment pair intersect and nearness pipeline.
// Takes one segment pair per cycle while o_stall is low and returns one word
// per pair, in order. The path from an accepted input word to o_valid runs
// through the differences, cross products and hit test, a divider load
// stage, the interpolation quotient at one bit per pipeline stage
// (COORD_BITS stages), then the truncation stage and the output register.
// The nearness tests run in parallel and are delayed to match. A two-entry
// output buffer keeps the pipeline moving while o_valid waits on i_stall;
// o_stall rises only once both entries are full.
`include "segment_pair_intersect_near_top_defines.svh"

module segment_pair_intersect_near_top #(
    parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COORD_BITS-1:0]      i_a_start_x,
    input  logic signed [COORD_BITS-1:0]      i_a_start_y,
    input  logic signed [COORD_BITS-1:0]      i_a_end_x,
    input  logic signed [COORD_BITS-1:0]      i_a_end_y,
    input  logic signed [COORD_BITS-1:0]      i_b_start_x,
    input  logic signed [COORD_BITS-1:0]      i_b_start_y,
    input  logic signed [COORD_BITS-1:0]      i_b_end_x,
    input  logic signed [COORD_BITS-1:0]      i_b_end_y,
    input  logic [sgi_pkg::LIMIT_BITS-1:0]    i_near_limit,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_hit,
    output logic signed [COORD_BITS-1:0]      o_cross_x,
    output logic signed [COORD_BITS-1:0]      o_cross_y,
    output logic                              o_near
);
    localparam int C   = COORD_BITS;
    localparam int DLY = C + 2;
    localparam int LAT = C + 9;

    logic en;

    logic                   c_hit;
    logic [2*C+1:0]         c_den;
    logic [3*C+1:0]         c_num_x, c_num_y;
    logic signed [C-1:0]    c_base_x, c_base_y;
    logic                   c_neg_x, c_neg_y;
    logic signed [C-1:0]    d_x, d_y;
    logic [3:0]             nr;

    logic [LAT-1:0]         r_vld;
    logic                   r_hd [0:DLY-1];
    logic                   r_nd [0:DLY-1];

    logic                   t_valid, t_hit, t_near;
    logic signed [C-1:0]    t_x, t_y;

    logic                   r_out_valid, r_out_hit, r_out_near;
    logic signed [C-1:0]    r_out_x, r_out_y;
    logic                   r_sk_valid, r_sk_hit, r_sk_near;
    logic signed [C-1:0]    r_sk_x, r_sk_y;

    assign en      = !r_sk_valid;
    assign o_stall = r_sk_valid;

    sgi_cross #(.C(C)) u_cross (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x1    (i_a_start_x),
        .i_y1    (i_a_start_y),
        .i_x2    (i_a_end_x),
        .i_y2    (i_a_end_y),
        .i_x3    (i_b_start_x),
        .i_y3    (i_b_start_y),
        .i_x4    (i_b_end_x),
        .i_y4    (i_b_end_y),
        .o_hit   (c_hit),
        .o_den   (c_den),
        .o_num_x (c_num_x),
        .o_num_y (c_num_y),
        .o_base_x(c_base_x),
        .o_base_y(c_base_y),
        .o_neg_x (c_neg_x),
        .o_neg_y (c_neg_y)
    );

    sgi_div #(.C(C)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (c_num_x),
        .i_den (c_den),
        .i_base(c_base_x),
        .i_neg (c_neg_x),
        .o_val (d_x)
    );

    sgi_div #(.C(C)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (c_num_y),
        .i_den (c_den),
        .i_base(c_base_y),
        .i_neg (c_neg_y),
        .o_val (d_y)
    );

    sgi_near #(.C(C)) u_near_a0 (
        .i_clk(i_clk), .i_en(en),
        .i_px(i_a_start_x), .i_py(i_a_start_y),
        .i_ax(i_b_start_x), .i_ay(i_b_start_y),
        .i_bx(i_b_end_x),   .i_by(i_b_end_y),
        .i_lim(i_near_limit), .o_near(nr[0])
    );

    sgi_near #(.C(C)) u_near_a1 (
        .i_clk(i_clk), .i_en(en),
        .i_px(i_a_end_x),   .i_py(i_a_end_y),
        .i_ax(i_b_start_x), .i_ay(i_b_start_y),
        .i_bx(i_b_end_x),   .i_by(i_b_end_y),
        .i_lim(i_near_limit), .o_near(nr[1])
    );

    sgi_near #(.C(C)) u_near_b0 (
        .i_clk(i_clk), .i_en(en),
        .i_px(i_b_start_x), .i_py(i_b_start_y),
        .i_ax(i_a_start_x), .i_ay(i_a_start_y),
        .i_bx(i_a_end_x),   .i_by(i_a_end_y),
        .i_lim(i_near_limit), .o_near(nr[2])
    );

    sgi_near #(.C(C)) u_near_b1 (
        .i_clk(i_clk), .i_en(en),
        .i_px(i_b_end_x),   .i_py(i_b_end_y),
        .i_ax(i_a_start_x), .i_ay(i_a_start_y),
        .i_bx(i_a_end_x),   .i_by(i_a_end_y),
        .i_lim(i_near_limit), .o_near(nr[3])
    );

    // align hit and near flags with the quotient pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd[0] <= c_hit;
            r_nd[0] <= |nr;
            for (int k = 1; k < DLY; k++) begin
                r_hd[k] <= r_hd[k-1];
                r_nd[k] <= r_nd[k-1];
            end
        end
    end

    assign t_valid = en && r_vld[LAT-1];
    assign t_hit   = r_hd[DLY-1];
    assign t_near  = r_hd[DLY-1] || r_nd[DLY-1];
    assign t_x     = r_hd[DLY-1] ? d_x : '0;
    assign t_y     = r_hd[DLY-1] ? d_y : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], i_valid};
            end
            if (!r_out_valid || !i_stall) begin
                if (r_sk_valid) begin
                    r_out_valid <= 1'b1;
                    r_out_hit   <= r_sk_hit;
                    r_out_near  <= r_sk_near;
                    r_out_x     <= r_sk_x;
                    r_out_y     <= r_sk_y;
                    r_sk_valid  <= 1'b0;
                end else begin
                    r_out_valid <= t_valid;
                    r_out_hit   <= t_hit;
                    r_out_near  <= t_near;
                    r_out_x     <= t_x;
                    r_out_y     <= t_y;
                end
            end else if (t_valid) begin
                r_sk_valid <= 1'b1;
                r_sk_hit   <= t_hit;
                r_sk_near  <= t_near;
                r_sk_x     <= t_x;
                r_sk_y     <= t_y;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_hit     = r_out_hit;
    assign o_near    = r_out_near;
    assign o_cross_x = r_out_x;
    assign o_cross_y = r_out_y;

    `SGI_CHK(a_near_on_hit, (r_out_valid && r_out_hit) |-> r_out_near, "hit word without near")
    `SGI_CHK(a_zero_miss, (r_out_valid && !r_out_hit) |-> (r_out_x == '0 && r_out_y == '0),
             "miss word with nonzero point")
    `SGI_CHK(a_skid_fill, (!r_sk_valid && !(r_out_valid && i_stall)) |=> !r_sk_valid,
             "skid filled while output free")
    `SGI_CHK(a_skid_out, r_sk_valid |-> r_out_valid, "skid holds word with output empty")
endmodule

// File: rtl/sgi_cross.sv
// Cross products, hit test and interpolation numerators, seven stages.
module sgi_cross #(
    parameter int C = sgi_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [C-1:0]     i_x1,
    input  logic signed [C-1:0]     i_y1,
    input  logic signed [C-1:0]     i_x2,
    input  logic signed [C-1:0]     i_y2,
    input  logic signed [C-1:0]     i_x3,
    input  logic signed [C-1:0]     i_y3,
    input  logic signed [C-1:0]     i_x4,
    input  logic signed [C-1:0]     i_y4,
    output logic                    o_hit,
    output logic [2*C+1:0]          o_den,
    output logic [3*C+1:0]          o_num_x,
    output logic [3*C+1:0]          o_num_y,
    output logic signed [C-1:0]     o_base_x,
    output logic signed [C-1:0]     o_base_y,
    output logic                    o_neg_x,
    output logic                    o_neg_y
);
    localparam int D  = C + 1;
    localparam int P  = 2 * C + 3;
    localparam int DW = P - 1;
    localparam int K  = (DW + 1) / 2;
    localparam int H  = DW - K;
    localparam int NW = DW + C;

    // stage 1
    logic signed [D-1:0] r_rx, r_ry, r_sx, r_sy, r_qx, r_qy;
    logic signed [C-1:0] r_bx1, r_by1;
    // stage 2
    logic signed [2*D-1:0] r_pd0, r_pd1, r_pt0, r_pt1, r_pu0, r_pu1;
    logic [C-1:0] r_arx2, r_ary2;
    logic r_nx2, r_ny2;
    logic signed [C-1:0] r_bx2, r_by2;
    // stage 3
    logic signed [P-1:0] r_d3, r_tn3, r_un3;
    logic [C-1:0] r_arx3, r_ary3;
    logic r_nx3, r_ny3;
    logic signed [C-1:0] r_bx3, r_by3;
    // stage 4
    logic signed [P-1:0] r_d4, r_tn4, r_un4;
    logic [C-1:0] r_arx4, r_ary4;
    logic r_nx4, r_ny4;
    logic signed [C-1:0] r_bx4, r_by4;
    // stage 5
    logic r_hit5;
    logic [DW-1:0] r_den5, r_tn5;
    logic [C-1:0] r_arx5, r_ary5;
    logic r_nx5, r_ny5;
    logic signed [C-1:0] r_bx5, r_by5;
    // stage 6
    logic r_hit6;
    logic [DW-1:0] r_den6;
    logic [H+C-1:0] r_nxh, r_nyh;
    logic [K+C-1:0] r_nxl, r_nyl;
    logic r_nx6, r_ny6;
    logic signed [C-1:0] r_bx6, r_by6;
    // stage 7
    logic r_hit7;
    logic [DW-1:0] r_den7;
    logic [NW-1:0] r_numx7, r_numy7;
    logic r_nx7, r_ny7;
    logic signed [C-1:0] r_bx7, r_by7;

    logic signed [D-1:0] n_neg_rx, n_neg_ry;
    logic n_hit;

    assign n_neg_rx = -r_rx;
    assign n_neg_ry = -r_ry;
    assign n_hit = (r_d4 != '0) && !r_tn4[P-1] && (r_tn4 <= r_d4)
                   && !r_un4[P-1] && (r_un4 <= r_d4);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx  <= $signed({i_x2[C-1], i_x2}) - $signed({i_x1[C-1], i_x1});
            r_ry  <= $signed({i_y2[C-1], i_y2}) - $signed({i_y1[C-1], i_y1});
            r_sx  <= $signed({i_x4[C-1], i_x4}) - $signed({i_x3[C-1], i_x3});
            r_sy  <= $signed({i_y4[C-1], i_y4}) - $signed({i_y3[C-1], i_y3});
            r_qx  <= $signed({i_x3[C-1], i_x3}) - $signed({i_x1[C-1], i_x1});
            r_qy  <= $signed({i_y3[C-1], i_y3}) - $signed({i_y1[C-1], i_y1});
            r_bx1 <= i_x1;
            r_by1 <= i_y1;

            r_pd0  <= r_rx * r_sy;
            r_pd1  <= r_ry * r_sx;
            r_pt0  <= r_qx * r_sy;
            r_pt1  <= r_qy * r_sx;
            r_pu0  <= r_qx * r_ry;
            r_pu1  <= r_qy * r_rx;
            r_arx2 <= r_rx[D-1] ? n_neg_rx[C-1:0] : r_rx[C-1:0];
            r_ary2 <= r_ry[D-1] ? n_neg_ry[C-1:0] : r_ry[C-1:0];
            r_nx2  <= r_rx[D-1];
            r_ny2  <= r_ry[D-1];
            r_bx2  <= r_bx1;
            r_by2  <= r_by1;

            r_d3   <= $signed({r_pd0[2*D-1], r_pd0}) - $signed({r_pd1[2*D-1], r_pd1});
            r_tn3  <= $signed({r_pt0[2*D-1], r_pt0}) - $signed({r_pt1[2*D-1], r_pt1});
            r_un3  <= $signed({r_pu0[2*D-1], r_pu0}) - $signed({r_pu1[2*D-1], r_pu1});
            r_arx3 <= r_arx2;
            r_ary3 <= r_ary2;
            r_nx3  <= r_nx2;
            r_ny3  <= r_ny2;
            r_bx3  <= r_bx2;
            r_by3  <= r_by2;

            r_d4   <= r_d3[P-1] ? -r_d3 : r_d3;
            r_tn4  <= r_d3[P-1] ? -r_tn3 : r_tn3;
            r_un4  <= r_d3[P-1] ? -r_un3 : r_un3;
            r_arx4 <= r_arx3;
            r_ary4 <= r_ary3;
            r_nx4  <= r_nx3;
            r_ny4  <= r_ny3;
            r_bx4  <= r_bx3;
            r_by4  <= r_by3;

            r_hit5 <= n_hit;
            r_den5 <= r_d4[DW-1:0];
            r_tn5  <= n_hit ? r_tn4[DW-1:0] : '0;
            r_arx5 <= r_arx4;
            r_ary5 <= r_ary4;
            r_nx5  <= r_nx4;
            r_ny5  <= r_ny4;
            r_bx5  <= r_bx4;
            r_by5  <= r_by4;

            r_hit6 <= r_hit5;
            r_den6 <= r_den5;
            r_nxh  <= r_tn5[DW-1:K] * r_arx5;
            r_nxl  <= r_tn5[K-1:0] * r_arx5;
            r_nyh  <= r_tn5[DW-1:K] * r_ary5;
            r_nyl  <= r_tn5[K-1:0] * r_ary5;
            r_nx6  <= r_nx5;
            r_ny6  <= r_ny5;
            r_bx6  <= r_bx5;
            r_by6  <= r_by5;

            r_hit7  <= r_hit6;
            r_den7  <= r_den6;
            r_numx7 <= (NW'(r_nxh) << K) + NW'(r_nxl);
            r_numy7 <= (NW'(r_nyh) << K) + NW'(r_nyl);
            r_nx7   <= r_nx6;
            r_ny7   <= r_ny6;
            r_bx7   <= r_bx6;
            r_by7   <= r_by6;
        end
    end

    assign o_hit    = r_hit7;
    assign o_den    = r_den7;
    assign o_num_x  = r_numx7;
    assign o_num_y  = r_numy7;
    assign o_base_x = r_bx7;
    assign o_base_y = r_by7;
    assign o_neg_x  = r_nx7;
    assign o_neg_y  = r_ny7;
endmodule

// File: rtl/sgi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with truncating offset.
module sgi_div #(
    parameter int C = sgi_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [3*C+1:0]          i_num,
    input  logic [2*C+1:0]          i_den,
    input  logic signed [C-1:0]     i_base,
    input  logic                    i_neg,
    output logic signed [C-1:0]     o_val
);
    localparam int DW = 2 * C + 2;
    localparam int NW = DW + C;
    localparam int Q  = C;

    logic [DW-1:0]       r_rem  [0:Q];
    logic [Q-1:0]        r_low  [0:Q];
    logic [Q-1:0]        r_quo  [0:Q];
    logic [DW-1:0]       r_den  [0:Q];
    logic signed [C-1:0] r_base [0:Q];
    logic                r_neg  [0:Q];
    logic signed [C-1:0] r_val;

    logic signed [C+1:0] n_sum;
    logic signed [C+1:0] n_val;
    logic                n_rnz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num[NW-1:Q];
            r_low[0]  <= i_num[Q-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_base[0] <= i_base;
            r_neg[0]  <= i_neg;
        end
    end

    for (genvar k = 0; k < Q; k++) begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        assign trial = {r_rem[k], r_low[k][Q-1]};
        assign diff  = trial - {1'b0, r_den[k]};
        assign ge    = trial >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_low[k+1]  <= {r_low[k][Q-2:0], 1'b0};
                r_quo[k+1]  <= {r_quo[k][Q-2:0], ge};
                r_den[k+1]  <= r_den[k];
                r_base[k+1] <= r_base[k];
                r_neg[k+1]  <= r_neg[k];
            end
        end
    end

    // truncate toward zero: step back one when the remainder is nonzero
    always_comb begin
        n_rnz = r_rem[Q] != '0;
        if (r_neg[Q]) begin
            n_sum = $signed({{2{r_base[Q][C-1]}}, r_base[Q]}) - $signed({2'b00, r_quo[Q]});
            n_val = (n_rnz && (n_sum > 0)) ? n_sum - $signed((C+2)'(1)) : n_sum;
        end else begin
            n_sum = $signed({{2{r_base[Q][C-1]}}, r_base[Q]}) + $signed({2'b00, r_quo[Q]});
            n_val = (n_rnz && n_sum[C+1]) ? n_sum + $signed((C+2)'(1)) : n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val[C-1:0];
        end
    end

    assign o_val = r_val;
endmodule

// File: rtl/sgi_near.sv
// Point to segment distance test against a squared threshold, seven stages.
module sgi_near #(
    parameter int C = sgi_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [C-1:0]               i_px,
    input  logic signed [C-1:0]               i_py,
    input  logic signed [C-1:0]               i_ax,
    input  logic signed [C-1:0]               i_ay,
    input  logic signed [C-1:0]               i_bx,
    input  logic signed [C-1:0]               i_by,
    input  logic [sgi_pkg::LIMIT_BITS-1:0]    i_lim,
    output logic                              o_near
);
    localparam int D  = C + 1;
    localparam int P  = 2 * C + 3;
    localparam int CW = P - 1;
    localparam int K  = (CW + 1) / 2;
    localparam int H  = CW - K;
    localparam int LB = sgi_pkg::LIM2_BITS;
    localparam int LW = (P > LB) ? P : LB;
    localparam int SW = ((2 * CW > LB + CW) ? 2 * CW : LB + CW) + 1;

    logic signed [D-1:0]   r_rx, r_ry, r_wx, r_wy, r_ex, r_ey;
    logic [LB-1:0]         r_l2_1, r_l2_2, r_l2_3, r_l2_4;
    logic signed [2*D-1:0] r_rxx, r_ryy, r_rxw, r_ryw, r_wxx, r_wyy, r_exx, r_eyy, r_c0, r_c1;
    logic signed [P-1:0]   r_m3, r_dot3, r_dw3, r_de3, r_cr3;
    logic                  r_fs4, r_fe4, r_nw4, r_ne4;
    logic [CW-1:0]         r_c4, r_m4;
    logic                  r_fs5, r_fe5, r_nw5, r_ne5;
    logic [2*H-1:0]        r_chh;
    logic [H+K-1:0]        r_chl;
    logic [2*K-1:0]        r_cll;
    logic [LB+H-1:0]       r_lmh;
    logic [LB+K-1:0]       r_lml;
    logic                  r_fs6, r_fe6, r_nw6, r_ne6;
    logic [SW-1:0]         r_cc, r_lm;
    logic                  r_near;

    logic signed [P-1:0]   n_neg_cr;

    assign n_neg_cr = -r_cr3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx   <= $signed({i_bx[C-1], i_bx}) - $signed({i_ax[C-1], i_ax});
            r_ry   <= $signed({i_by[C-1], i_by}) - $signed({i_ay[C-1], i_ay});
            r_wx   <= $signed({i_px[C-1], i_px}) - $signed({i_ax[C-1], i_ax});
            r_wy   <= $signed({i_py[C-1], i_py}) - $signed({i_ay[C-1], i_ay});
            r_ex   <= $signed({i_px[C-1], i_px}) - $signed({i_bx[C-1], i_bx});
            r_ey   <= $signed({i_py[C-1], i_py}) - $signed({i_by[C-1], i_by});
            r_l2_1 <= i_lim * i_lim;

            r_rxx  <= r_rx * r_rx;
            r_ryy  <= r_ry * r_ry;
            r_rxw  <= r_rx * r_wx;
            r_ryw  <= r_ry * r_wy;
            r_wxx  <= r_wx * r_wx;
            r_wyy  <= r_wy * r_wy;
            r_exx  <= r_ex * r_ex;
            r_eyy  <= r_ey * r_ey;
            r_c0   <= r_rx * r_wy;
            r_c1   <= r_ry * r_wx;
            r_l2_2 <= r_l2_1;

            r_m3   <= $signed({r_rxx[2*D-1], r_rxx}) + $signed({r_ryy[2*D-1], r_ryy});
            r_dot3 <= $signed({r_rxw[2*D-1], r_rxw}) + $signed({r_ryw[2*D-1], r_ryw});
            r_dw3  <= $signed({r_wxx[2*D-1], r_wxx}) + $signed({r_wyy[2*D-1], r_wyy});
            r_de3  <= $signed({r_exx[2*D-1], r_exx}) + $signed({r_eyy[2*D-1], r_eyy});
            r_cr3  <= $signed({r_c0[2*D-1], r_c0}) - $signed({r_c1[2*D-1], r_c1});
            r_l2_3 <= r_l2_2;

            r_fs4  <= (r_m3 == '0) || (r_dot3 <= 0);
            r_fe4  <= r_dot3 >= r_m3;
            r_nw4  <= LW'($unsigned(r_dw3)) <= LW'(r_l2_3);
            r_ne4  <= LW'($unsigned(r_de3)) <= LW'(r_l2_3);
            r_c4   <= r_cr3[P-1] ? n_neg_cr[CW-1:0] : r_cr3[CW-1:0];
            r_m4   <= r_m3[CW-1:0];
            r_l2_4 <= r_l2_3;

            r_chh  <= r_c4[CW-1:K] * r_c4[CW-1:K];
            r_chl  <= r_c4[CW-1:K] * r_c4[K-1:0];
            r_cll  <= r_c4[K-1:0] * r_c4[K-1:0];
            r_lmh  <= r_l2_4 * r_m4[CW-1:K];
            r_lml  <= r_l2_4 * r_m4[K-1:0];
            r_fs5  <= r_fs4;
            r_fe5  <= r_fe4;
            r_nw5  <= r_nw4;
            r_ne5  <= r_ne4;

            r_cc   <= (SW'(r_chh) << (2 * K)) + (SW'(r_chl) << (K + 1)) + SW'(r_cll);
            r_lm   <= (SW'(r_lmh) << K) + SW'(r_lml);
            r_fs6  <= r_fs5;
            r_fe6  <= r_fe5;
            r_nw6  <= r_nw5;
            r_ne6  <= r_ne5;

            r_near <= r_fs6 ? r_nw6 : (r_fe6 ? r_ne6 : (r_cc <= r_lm));
        end
    end

    assign o_near = r_near;
endmodule
